// ===== rtl/core/spc_pkg.sv =====
package spc_pkg;

    localparam int IQ_W       = 16;
    localparam int POW_W      = 32;
    localparam int SUM_W      = 42;
    localparam int AVG_W      = 32;
    localparam int CLS_W      = 2;
    localparam int WIN_W      = 11;
    localparam int THR_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR_HIGH   = 2'd2;

    localparam logic [CLS_W-1:0] CLS_LOW  = 2'd0;
    localparam logic [CLS_W-1:0] CLS_MED  = 2'd1;
    localparam logic [CLS_W-1:0] CLS_HIGH = 2'd2;

    localparam logic [WIN_W-1:0] WIN_RESET      = 11'd64;
    localparam logic [THR_W-1:0] THR_LOW_RESET  = 32'h0000_0000;
    localparam logic [THR_W-1:0] THR_HIGH_RESET = 32'h8000_0000;

endpackage

// ===== rtl/core/spc_hist.sv =====
module spc_hist
    import spc_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [POW_W-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [POW_W-1:0] i_wr_data
);

    logic [POW_W-1:0] r_mem [DEPTH];
    logic [POW_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/spc_power.sv =====
module spc_power
    import spc_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [IQ_W-1:0]  i_sample_i,
    input  logic [IQ_W-1:0]  i_sample_q,
    output logic [POW_W-1:0] o_power
);

    localparam int SB   = SAMPLE_BITS;
    localparam int FRAC = 2 * (SB - 1);
    localparam int LSH  = (FRAC <= 30) ? (30 - FRAC) : 0;
    localparam int RSH  = (FRAC > 30) ? (FRAC - 30) : 0;
    localparam int PW   = 2 * SB + 32;

    logic [SB+IQ_W-1:0]    ext_i;
    logic [SB+IQ_W-1:0]    ext_q;
    logic signed [SB-1:0]  si;
    logic signed [SB-1:0]  sq;
    logic signed [2*SB-1:0] prod_i;
    logic signed [2*SB-1:0] prod_q;
    logic [2*SB-1:0]       r_sq_i;
    logic [2*SB-1:0]       r_sq_q;
    logic [2*SB:0]         raw;
    logic [PW-1:0]         scaled;

    assign ext_i  = {{SB{1'b0}}, i_sample_i};
    assign ext_q  = {{SB{1'b0}}, i_sample_q};
    assign si     = $signed(ext_i[SB-1:0]);
    assign sq     = $signed(ext_q[SB-1:0]);
    assign prod_i = si * si;
    assign prod_q = sq * sq;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_i <= $unsigned(prod_i);
            r_sq_q <= $unsigned(prod_q);
        end
    end

    assign raw     = {1'b0, r_sq_i} + {1'b0, r_sq_q};
    assign scaled  = ({{(PW-2*SB-1){1'b0}}, raw} << LSH) >> RSH;
    assign o_power = scaled[POW_W-1:0];

endmodule

// ===== rtl/core/spc_div.sv =====
module spc_div
    import spc_pkg::*;
#(
    parameter int DVS_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [SUM_W-1:0] o_quot,
    output logic             o_done
);

    localparam int CW = $clog2(SUM_W + 1);

    logic [CW-1:0]    r_cnt;
    logic             r_done;
    logic [DVS_W-1:0] r_rem;
    logic [SUM_W-1:0] r_quo;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             qbit;
    logic [DVS_W-1:0] n_rem;
    logic [SUM_W-1:0] n_quo;

    always_comb begin
        trial = {r_rem, r_quo[SUM_W-1]};
        diff  = trial - {1'b0, i_divisor};
        qbit  = (trial >= {1'b0, i_divisor});
        n_rem = qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        n_quo = {r_quo[SUM_W-2:0], qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(SUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quot = r_quo;
    assign o_done = r_done;

endmodule

// ===== rtl/core/slot_power_classifier.sv =====
// Windowed power meter with a three-level class. Every input transfer carries one complex
// sample, which comes back unchanged in exactly one output transfer. The block keeps the
// powers I*I+Q*Q of the last window_len samples in a history memory and a running sum over
// them; on a sample flagged in tuser it also reports floor(sum / window_len) in unsigned
// Q2.30 and the class against the two thresholds. A sample is accepted as the oldest
// power is read; then the sum is updated and the new power written into the memory, and a
// flagged sample waits on a bit-serial divider that produces one of its 42 bits per cycle.
// A result enters the output register once that is free, and the next sample may then be
// accepted while it waits there. Entries not yet written since reset or a window_len write
// read as zero through a fill count, so no clearing pass is needed. The user must write
// configuration only while no sample is in flight; the block itself does not enforce it.
module slot_power_classifier
    import spc_pkg::*;
#(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // sample_i, sample_q
    input  logic                  s_axis_tuser,   // slot_begin
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [71:0]           m_axis_tdata,   // pass_i, pass_q, avg_power, quality_class
    output logic                  m_axis_tuser,   // report_valid
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WB = $clog2(MAX_WINDOW + 1);
    localparam int EW = (WB > WIN_W) ? WB : WIN_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [WIN_W-1:0] r_win;
    logic [THR_W-1:0] r_thr_lo;
    logic [THR_W-1:0] r_thr_hi;
    logic [SUM_W-1:0] r_sum;
    logic [AW-1:0]    r_wpos;
    logic [WB-1:0]    r_fill;
    logic             r_old_ok;
    logic             r_slot;
    logic [IQ_W-1:0]  r_pi;
    logic [IQ_W-1:0]  r_pq;
    logic [AVG_W-1:0] r_res_avg;
    logic             r_out_valid;
    logic [IQ_W-1:0]  r_o_pi;
    logic [IQ_W-1:0]  r_o_pq;
    logic             r_o_rep;
    logic [AVG_W-1:0] r_o_avg;
    logic [CLS_W-1:0] r_o_cls;

    logic [EW-1:0]    win_x;
    logic [WB-1:0]    eff;
    logic [WB:0]      old_x;
    logic [AW-1:0]    old_idx;
    logic             accept;
    logic             upd;
    logic [POW_W-1:0] power;
    logic [POW_W-1:0] rd_data;
    logic [POW_W-1:0] old_pow;
    logic [SUM_W-1:0] n_sum;
    logic [AW-1:0]    n_wpos;
    logic [SUM_W-1:0] quot;
    logic             div_done;
    logic             fin;
    logic             out_free;
    logic [AVG_W-1:0] res_avg;
    logic [CLS_W-1:0] res_cls;

    always_comb begin
        win_x = EW'(r_win);
        if (win_x == '0) begin
            eff = WB'(1);
        end else if (win_x > EW'(MAX_WINDOW)) begin
            eff = WB'(MAX_WINDOW);
        end else begin
            eff = win_x[WB-1:0];
        end
    end

    always_comb begin
        if ({{(WB+1-AW){1'b0}}, r_wpos} >= {1'b0, eff}) begin
            old_x = {{(WB+1-AW){1'b0}}, r_wpos} - {1'b0, eff};
        end else begin
            old_x = {{(WB+1-AW){1'b0}}, r_wpos} + (WB+1)'(MAX_WINDOW) - {1'b0, eff};
        end
        old_idx = old_x[AW-1:0];
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign upd           = (r_state == S_UPD);

    spc_hist #(
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (old_idx),
        .o_rd_data (rd_data),
        .i_wr_en   (upd),
        .i_wr_addr (r_wpos),
        .i_wr_data (power)
    );

    spc_power #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_power (
        .i_clk      (i_clk),
        .i_en       (accept),
        .i_sample_i (s_axis_tdata[15:0]),
        .i_sample_q (s_axis_tdata[31:16]),
        .o_power    (power)
    );

    assign old_pow = r_old_ok ? rd_data : '0;
    assign n_sum   = r_sum - SUM_W'(old_pow) + SUM_W'(power);
    assign n_wpos  = (r_wpos == AW'(MAX_WINDOW - 1)) ? '0 : r_wpos + AW'(1);

    spc_div #(
        .DVS_W (WB)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (upd && r_slot),
        .i_dividend (n_sum),
        .i_divisor  (eff),
        .o_quot     (quot),
        .o_done     (div_done)
    );

    assign out_free = !r_out_valid || m_axis_tready;
    assign fin      = (upd && !r_slot) || ((r_state == S_DIV) && div_done)
                      || (r_state == S_OUT);

    always_comb begin
        if (!r_slot) begin
            res_avg = '0;
        end else if (r_state == S_OUT) begin
            res_avg = r_res_avg;
        end else begin
            res_avg = quot[AVG_W-1:0];
        end
        if (!r_slot) begin
            res_cls = CLS_LOW;
        end else if (res_avg < r_thr_lo) begin
            res_cls = CLS_LOW;
        end else if (res_avg > r_thr_hi) begin
            res_cls = CLS_HIGH;
        end else begin
            res_cls = CLS_MED;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (r_slot) begin
                    n_state = S_DIV;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = out_free ? S_IDLE : S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win       <= WIN_RESET;
            r_thr_lo    <= THR_LOW_RESET;
            r_thr_hi    <= THR_HIGH_RESET;
            r_sum       <= '0;
            r_wpos      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WINDOW_LEN: begin
                        r_win  <= i_cfg_data[WIN_W-1:0];
                        r_sum  <= '0;
                        r_wpos <= '0;
                        r_fill <= '0;
                    end
                    REG_THR_LOW:  r_thr_lo <= i_cfg_data[THR_W-1:0];
                    REG_THR_HIGH: r_thr_hi <= i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end else if (upd) begin
                r_sum  <= n_sum;
                r_wpos <= n_wpos;
                if (r_fill != WB'(MAX_WINDOW)) begin
                    r_fill <= r_fill + WB'(1);
                end
            end
            if (fin && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pi     <= s_axis_tdata[15:0];
            r_pq     <= s_axis_tdata[31:16];
            r_slot   <= s_axis_tuser;
            r_old_ok <= (r_fill >= eff);
        end
        if (fin && !out_free) begin
            r_res_avg <= res_avg;
        end
        if (fin && out_free) begin
            r_o_pi  <= r_pi;
            r_o_pq  <= r_pq;
            r_o_rep <= r_slot;
            r_o_avg <= res_avg;
            r_o_cls <= res_cls;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_o_cls, r_o_avg, r_o_pq, r_o_pi};
    assign m_axis_tuser  = r_o_rep;

endmodule

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import spc_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int PRINT_LIMIT = 30;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [IQ_W-1:0] i;
        logic signed [IQ_W-1:0] q;
        logic                   slot;
    } t_sample;

    typedef struct packed {
        logic signed [IQ_W-1:0] i;
        logic signed [IQ_W-1:0] q;
        logic                   rv;
        logic [AVG_W-1:0]       avg;
        logic [CLS_W-1:0]       cls;
    } t_report;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata = '0;    // sample_i, sample_q
    logic                  s_axis_tuser = 1'b0;  // slot_begin
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [71:0]           m_axis_tdata;         // pass_i, pass_q, avg_power, quality_class
    logic                  m_axis_tuser;         // report_valid
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    slot_power_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    logic [POW_W-1:0] power_line [DEPTH];
    logic [SUM_W-1:0] line_sum;
    int               line_pos;
    logic [WIN_W-1:0] win_reg;
    logic [THR_W-1:0] thr_lo_reg;
    logic [THR_W-1:0] thr_hi_reg;

    t_sample pending_samples[$];
    t_report expected_reports[$];
    t_sample on_bus;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int n_errors = 0;
    int n_samples = 0;
    int n_reports = 0;
    int n_writes = 0;

    function automatic void clear_line();
        foreach (power_line[k]) power_line[k] = '0;
        line_sum = '0;
        line_pos = 0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_WINDOW_LEN: begin
                win_reg = data[WIN_W-1:0];
                clear_line();
            end
            REG_THR_LOW:  thr_lo_reg = data;
            REG_THR_HIGH: thr_hi_reg = data;
            default: ;
        endcase
    endfunction

    function automatic t_report measure_sample(input t_sample s);
        longint           ii;
        longint           qq;
        int               w;
        int               old_idx;
        logic [POW_W-1:0] p;
        logic [SUM_W-1:0] quo;
        t_report          r;
        ii = longint'(s.i);
        qq = longint'(s.q);
        w = int'(win_reg);
        if (w == 0) w = 1;
        if (w > DEPTH) w = DEPTH;
        p = POW_W'(ii * ii + qq * qq);
        old_idx = (line_pos + DEPTH - w) % DEPTH;
        line_sum = line_sum - power_line[old_idx] + p;
        power_line[line_pos] = p;
        line_pos = (line_pos + 1) % DEPTH;
        r.i = s.i;
        r.q = s.q;
        r.rv = s.slot;
        r.avg = '0;
        r.cls = CLS_LOW;
        if (s.slot) begin
            quo = line_sum / SUM_W'(w);
            r.avg = quo[AVG_W-1:0];
            if (r.avg < thr_lo_reg) r.cls = CLS_LOW;
            else if (r.avg > thr_hi_reg) r.cls = CLS_HIGH;
            else r.cls = CLS_MED;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        n_errors++;
        if (n_errors <= PRINT_LIMIT)
            $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    task automatic check_report();
        t_report want;
        if (expected_reports.size() == 0) begin
            report_mismatch("unexpected transfer", m_axis_tdata[63:0], '0);
        end else begin
            want = expected_reports.pop_front();
            if (want.rv) n_reports++;
            if (m_axis_tdata[15:0] !== want.i)
                report_mismatch("pass_i", 64'(m_axis_tdata[15:0]), 64'($unsigned(want.i)));
            if (m_axis_tdata[31:16] !== want.q)
                report_mismatch("pass_q", 64'(m_axis_tdata[31:16]), 64'($unsigned(want.q)));
            if (m_axis_tuser !== want.rv)
                report_mismatch("report_valid", 64'(m_axis_tuser), 64'(want.rv));
            if (m_axis_tdata[63:32] !== want.avg)
                report_mismatch("avg_power", 64'(m_axis_tdata[63:32]), 64'(want.avg));
            if (m_axis_tdata[65:64] !== want.cls)
                report_mismatch("quality_class", 64'(m_axis_tdata[65:64]), 64'(want.cls));
        end
    endtask

    always @(posedge i_clk) begin : drive
        t_sample nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_reports.push_back(measure_sample(on_bus));
                n_samples++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_samples.pop_front();
                    on_bus <= nxt;
                    s_axis_tdata <= {nxt.q, nxt.i};
                    s_axis_tuser <= nxt.slot;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_report();
            if (hold_seen != hold_req) begin
                hold_seen <= hold_req;
                hold_left <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic push_sample(input int i, input int q, input logic slot);
        t_sample s;
        s.i = i[IQ_W-1:0];
        s.q = q[IQ_W-1:0];
        s.slot = slot;
        pending_samples.push_back(s);
    endtask

    function automatic int rand_part();
        int v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: v = $signed(16'($urandom));
            5, 6:          v = int'($urandom_range(2047)) - 1024;
            7: begin
                case ($urandom_range(3))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            default: begin
                v = $urandom_range(32767, 24000);
                if ($urandom_range(1)) v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic logic [THR_W-1:0] rand_extreme_thr();
        case ($urandom_range(3))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WIN_W-1:0] pick_window(input int ph);
        case (ph)
            0: return 11'd1;
            1: return 11'd1024;
            2: return 11'd0;
            3: return 11'd2047;
            default: begin
                case ($urandom_range(3))
                    0: return WIN_W'($urandom_range(16, 1));
                    1: return WIN_W'($urandom_range(1024, 17));
                    2: return WIN_W'($urandom_range(2047, 1025));
                    default: return WIN_RESET;
                endcase
            end
        endcase
    endfunction

    // Returns once nothing is queued, offered or outstanding, on a falling edge.
    task automatic drain(input int extra);
        while (pending_samples.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
            @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        apply_reg(idx, data);
        n_writes++;
    endtask

    task automatic close_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    int pace_send [8] = '{0, 85, 0, 31, 0, 85, 0, 31};
    int pace_recv [8] = '{0, 0, 85, 31, 0, 0, 85, 31};

    initial begin
        logic [THR_W-1:0]      lo;
        logic [THR_W-1:0]      hi;
        logic [CFG_DATA_W-1:0] wdata;
        win_reg = WIN_RESET;
        thr_lo_reg = THR_LOW_RESET;
        thr_hi_reg = THR_HIGH_RESET;
        clear_line();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_sample(32767, 32767, 1'b1);
        push_sample(-32768, -32768, 1'b1);
        push_sample(-32768, 32767, 1'b0);
        push_sample(0, 0, 1'b1);
        push_sample(-1, 1, 1'b1);
        push_sample(32767, -32768, 1'b1);
        drain(8);

        write_reg(REG_WINDOW_LEN, 32'd0);
        write_reg(REG_THR_LOW, 32'h4000_0000);
        write_reg(REG_THR_HIGH, 32'h8000_0000);
        close_writes();
        push_sample(0, 0, 1'b1);
        push_sample(-32768, 0, 1'b1);
        push_sample(-32768, -1, 1'b1);
        push_sample(-32768, -32768, 1'b1);
        drain(8);

        write_reg(REG_THR_HIGH, 32'h7FFF_FFFF);
        write_reg(REG_UNUSED, $urandom);
        close_writes();
        push_sample(-32768, -32768, 1'b1);
        push_sample(32767, 32767, 1'b0);
        push_sample(100, 0, 1'b1);
        drain(8);

        // Crossed thresholds, window clamped to the maximum.
        write_reg(REG_WINDOW_LEN, 32'd2047);
        write_reg(REG_THR_LOW, 32'h4000_0000);
        write_reg(REG_THR_HIGH, 32'h0000_1000);
        close_writes();
        push_sample(0, 0, 1'b1);
        push_sample(32767, 32767, 1'b1);
        push_sample(-32768, -32768, 1'b1);
        push_sample(20, -30, 1'b1);
        drain(8);

        for (int ph = 0; ph < 8; ph++) begin
            if (ph != 5) begin
                wdata = CFG_DATA_W'(pick_window(ph));
                if ($urandom_range(1)) wdata = ($urandom & ~32'h7FF) | wdata;
                write_reg(REG_WINDOW_LEN, wdata);
            end
            if ($urandom_range(9) < 7) begin
                lo = $urandom_range(32'h3000_0000, 0);
                hi = lo + $urandom_range(32'h2000_0000, 0);
            end else begin
                lo = rand_extreme_thr();
                hi = rand_extreme_thr();
            end
            write_reg(REG_THR_LOW, lo);
            write_reg(REG_THR_HIGH, hi);
            if (ph == 6) write_reg(REG_UNUSED, $urandom);
            close_writes();
            send_idle_pct = pace_send[ph];
            recv_stall_pct = pace_recv[ph];
            if (ph == 4) hold_req++;
            for (int k = 0; k < 100; k++)
                push_sample(rand_part(), rand_part(), $urandom_range(99) < 18);
            drain(8);
        end

        drain(50);
        $display("Sent %0d samples through %0d register writes; %0d measurements were checked.",
                 n_samples, n_writes, n_reports);
        $display("Covered clamped windows, crossed thresholds and long output back-pressure.");
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
